[sv/dual_bank_image_selector_defines.svh]
// Assertion macros for the dual bank image selector.
`ifndef DUAL_BANK_IMAGE_SELECTOR_DEFINES_SVH
`define DUAL_BANK_IMAGE_SELECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define DBIS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define DBIS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define DBIS_ASSERT(label, prop, msg)
`define DBIS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[sv/dbis_pkg.sv]
`default_nettype none
package dbis_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_MAGIC  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_IMAGE_BYTES = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_SCHEMA = 2'd2;

   localparam logic [1:0] OP_HEADER = 2'd0;
   localparam logic [1:0] OP_DATA   = 2'd1;
   localparam logic [1:0] OP_DECIDE = 2'd2;

   localparam logic [1:0] ACTIVE_A    = 2'd0;
   localparam logic [1:0] ACTIVE_B    = 2'd1;
   localparam logic [1:0] ACTIVE_NONE = 2'd2;

   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0] CRC_SEED  = 32'hFFFFFFFF;
   localparam logic [16:0] COUNT_SAT = 17'h1FFFF;
   localparam logic [16:0] MAX_BYTES_RESET = 17'h10000;

   typedef struct packed {
      logic [1:0]  operation;
      logic        bank;
      logic [31:0] magic;
      logic [31:0] valid_flag;
      logic [31:0] size_bytes;
      logic [31:0] crc_value;
      logic [31:0] sequence_req;
      logic [63:0] schema_tag;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      logic        load_header;
      logic        load_data;
      logic        header_ok;
      logic [31:0] size_bytes;
      logic [31:0] crc_value;
      logic [31:0] seq_num;
      logic [7:0]  data_byte;
   } bank_cmd_type;

   typedef struct packed {
      logic        good;
      logic [31:0] seq_num;
   } bank_status_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
      logic [31:0] c;
      c = crc_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[sv/dbis_req_if.sv]
`default_nettype none
interface dbis_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic        bank;
   logic [31:0] magic;
   logic [31:0] valid_flag;
   logic [31:0] size_bytes;
   logic [31:0] crc_value;
   logic [31:0] sequence_req;
   logic [63:0] schema_tag;
   logic [7:0]  data_byte;

   modport source (
      output valid, operation, bank, magic, valid_flag, size_bytes, crc_value,
             sequence_req, schema_tag, data_byte,
      input  ready
   );
   modport sink (
      input  valid, operation, bank, magic, valid_flag, size_bytes, crc_value,
             sequence_req, schema_tag, data_byte,
      output ready
   );
endinterface
`default_nettype wire

[sv/dbis_rsp_if.sv]
`default_nettype none
interface dbis_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  active_bank;
   logic [31:0] active_sequence;
   logic        bank_a_good;
   logic        bank_b_good;
   logic        next_target_bank;
   logic [31:0] next_sequence;

   modport source (
      output valid, active_bank, active_sequence, bank_a_good, bank_b_good,
             next_target_bank, next_sequence,
      input  ready
   );
   modport sink (
      input  valid, active_bank, active_sequence, bank_a_good, bank_b_good,
             next_target_bank, next_sequence,
      output ready
   );
endinterface
`default_nettype wire

[sv/dbis_bank.sv]
`default_nettype none
module dbis_bank (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dbis_pkg::bank_cmd_type   cmd,
   output dbis_pkg::bank_status_type     status
);
   import dbis_pkg::*;

   logic        header_ok_ff, header_ok_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] run_crc_ff, run_crc_in;
   logic [16:0] count_ff, count_in;

   always_comb begin
      header_ok_in = header_ok_ff;
      size_in      = size_ff;
      crc_in       = crc_ff;
      seq_in       = seq_ff;
      run_crc_in   = run_crc_ff;
      count_in     = count_ff;
      if (cmd.load_header) begin
         header_ok_in = cmd.header_ok;
         size_in      = cmd.size_bytes;
         crc_in       = cmd.crc_value;
         seq_in       = cmd.seq_num;
         run_crc_in   = CRC_SEED;
         count_in     = '0;
      end else if (cmd.load_data) begin
         run_crc_in = crc_byte(run_crc_ff, cmd.data_byte);
         if (count_ff != COUNT_SAT) begin
            count_in = count_ff + 17'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ok_ff <= 1'b0;
         size_ff      <= '0;
         crc_ff       <= '0;
         seq_ff       <= '0;
         run_crc_ff   <= CRC_SEED;
         count_ff     <= '0;
      end else begin
         header_ok_ff <= header_ok_in;
         size_ff      <= size_in;
         crc_ff       <= crc_in;
         seq_ff       <= seq_in;
         run_crc_ff   <= run_crc_in;
         count_ff     <= count_in;
      end
   end

   assign status.good = header_ok_ff && (count_ff != COUNT_SAT) &&
                        ({15'd0, count_ff} == size_ff) && (~run_crc_ff == crc_ff);
   assign status.seq_num = seq_ff;

endmodule
`default_nettype wire

[sv/dual_bank_image_selector.sv]
// Decide path: a decide item is taken into the input register, and its result is registered in the output register.
// Throughput: one item per cycle; header and data items move on even while
// a result waits, a decide item waits for the output register to free up.
// Reset: synchronous, active high; clears both bank states (CRC to all ones)
// and restores config registers to defaults.
`default_nettype none
`include "dual_bank_image_selector_defines.svh"
module dual_bank_image_selector #(
   parameter int MAX_IMAGE_LIMIT = 65536
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   dbis_req_if.sink                               req_chan,
   dbis_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_write_enable,
   input  wire logic [dbis_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [dbis_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import dbis_pkg::*;

   localparam logic [31:0] LIMIT = 32'(MAX_IMAGE_LIMIT);

   logic [31:0] magic_cfg_ff;
   logic [16:0] max_bytes_cfg_ff;
   logic [63:0] schema_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_cfg_ff     <= '0;
         max_bytes_cfg_ff <= MAX_BYTES_RESET;
         schema_cfg_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EXPECTED_MAGIC:  magic_cfg_ff     <= csr_write_data[31:0];
            CSR_MAX_IMAGE_BYTES: max_bytes_cfg_ff <= csr_write_data[16:0];
            CSR_EXPECTED_SCHEMA: schema_cfg_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   logic         out_valid_ff, out_valid_in;
   logic         s1_decide, s1_fire, req_take;

   assign s1_decide = s1_item_ff.operation == OP_DECIDE;
   assign s1_fire   = s1_valid_ff && (!s1_decide || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_take  = req_chan.valid && req_chan.ready;
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.operation    <= req_chan.operation;
         s1_item_ff.bank         <= req_chan.bank;
         s1_item_ff.magic        <= req_chan.magic;
         s1_item_ff.valid_flag   <= req_chan.valid_flag;
         s1_item_ff.size_bytes   <= req_chan.size_bytes;
         s1_item_ff.crc_value    <= req_chan.crc_value;
         s1_item_ff.sequence_req <= req_chan.sequence_req;
         s1_item_ff.schema_tag   <= req_chan.schema_tag;
         s1_item_ff.data_byte    <= req_chan.data_byte;
      end
   end

   // header check
   logic [31:0] max_bytes_ext, size_limit;
   logic        header_ok;

   assign max_bytes_ext = {15'd0, max_bytes_cfg_ff};
   assign size_limit    = (max_bytes_ext > LIMIT) ? LIMIT : max_bytes_ext;
   assign header_ok = (s1_item_ff.magic == magic_cfg_ff) &&
                      (s1_item_ff.valid_flag == 32'd1) &&
                      (s1_item_ff.size_bytes != 32'd0) &&
                      (s1_item_ff.size_bytes <= size_limit) &&
                      (s1_item_ff.schema_tag == schema_cfg_ff);

   bank_cmd_type    cmd_a, cmd_b;
   bank_status_type stat_a, stat_b;
   logic            fire_header, fire_data;

   assign fire_header = s1_fire && (s1_item_ff.operation == OP_HEADER);
   assign fire_data   = s1_fire && (s1_item_ff.operation == OP_DATA);

   always_comb begin
      cmd_a.load_header = fire_header && !s1_item_ff.bank;
      cmd_a.load_data   = fire_data && !s1_item_ff.bank;
      cmd_a.header_ok   = header_ok;
      cmd_a.size_bytes  = s1_item_ff.size_bytes;
      cmd_a.crc_value   = s1_item_ff.crc_value;
      cmd_a.seq_num     = s1_item_ff.sequence_req;
      cmd_a.data_byte   = s1_item_ff.data_byte;
      cmd_b             = cmd_a;
      cmd_b.load_header = fire_header && s1_item_ff.bank;
      cmd_b.load_data   = fire_data && s1_item_ff.bank;
   end

   dbis_bank u_bank_a (.clock(clock), .reset(reset), .cmd(cmd_a), .status(stat_a));
   dbis_bank u_bank_b (.clock(clock), .reset(reset), .cmd(cmd_b), .status(stat_b));

   // selection
   logic [1:0]  act_sel;
   logic [31:0] seq_sel;

   always_comb begin
      if (stat_a.good && stat_b.good) begin
         if (stat_b.seq_num > stat_a.seq_num) begin
            act_sel = ACTIVE_B;
            seq_sel = stat_b.seq_num;
         end else begin
            act_sel = ACTIVE_A;
            seq_sel = stat_a.seq_num;
         end
      end else if (stat_a.good) begin
         act_sel = ACTIVE_A;
         seq_sel = stat_a.seq_num;
      end else if (stat_b.good) begin
         act_sel = ACTIVE_B;
         seq_sel = stat_b.seq_num;
      end else begin
         act_sel = ACTIVE_NONE;
         seq_sel = '0;
      end
   end

   // result register
   logic        fire_decide;
   logic [1:0]  act_ff;
   logic [31:0] seq_ff;
   logic        a_good_ff, b_good_ff, target_ff;
   logic [31:0] next_seq_ff;

   assign fire_decide = s1_fire && s1_decide;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire_decide) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_decide) begin
         act_ff      <= act_sel;
         seq_ff      <= seq_sel;
         a_good_ff   <= stat_a.good;
         b_good_ff   <= stat_b.good;
         target_ff   <= act_sel == ACTIVE_A;
         next_seq_ff <= seq_sel + 32'd1;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.active_bank      = act_ff;
   assign rsp_chan.active_sequence  = seq_ff;
   assign rsp_chan.bank_a_good      = a_good_ff;
   assign rsp_chan.bank_b_good      = b_good_ff;
   assign rsp_chan.next_target_bank = target_ff;
   assign rsp_chan.next_sequence    = next_seq_ff;

   `DBIS_ASSERT(a_result_from_decide, $rose(out_valid_ff) |-> $past(s1_valid_ff && s1_decide), "result without decide")
   `DBIS_ASSERT(a_none_means_no_good, out_valid_ff && (act_ff == ACTIVE_NONE) |-> !a_good_ff && !b_good_ff && (seq_ff == 32'd0), "none chosen with good bank")
   `DBIS_ASSERT(a_chosen_is_good, out_valid_ff && (act_ff == ACTIVE_B) |-> b_good_ff && (!a_good_ff || (target_ff == 1'b0)), "bank B chosen but not good")
   `DBIS_ASSERT(a_decide_waits, s1_valid_ff && s1_decide && out_valid_ff && !rsp_chan.ready |=> s1_valid_ff && $stable(s1_item_ff), "decide item lost under stall")

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dbis_pkg::*;

   localparam int unsigned SIZE_CAP    = 65536;      // block's default MAX_IMAGE_LIMIT
   localparam int unsigned CYCLE_LIMIT = 200_000;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;

   typedef struct packed {
      logic [1:0]  active_bank;
      logic [31:0] active_sequence;
      logic        bank_a_good;
      logic        bank_b_good;
      logic        next_target_bank;
      logic [31:0] next_sequence;
   } verdict_type;

   typedef enum int {
      FLAW_NONE, FLAW_MAGIC, FLAW_VALID, FLAW_SIZE_ZERO, FLAW_OVERSIZE,
      FLAW_SCHEMA, FLAW_CRC, FLAW_SHORT, FLAW_LONG, FLAW_HEADERLESS
   } flaw_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   dbis_req_if req_bus ();
   dbis_rsp_if rsp_bus ();

   dual_bank_image_selector u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus.sink),
      .rsp_chan         (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // stimulus side
   req_item_type pending_items[$];
   req_item_type staged[2][$];
   int unsigned  image_items = 0;
   logic         quiet = 1'b0;
   logic [31:0]  stim_magic = '0;
   logic [16:0]  stim_limit = MAX_BYTES_RESET;
   logic [63:0]  stim_schema = '0;

   // bank selection predictor
   logic [31:0]  want_magic;
   logic [16:0]  size_limit;
   logic [63:0]  want_schema;
   logic         hdr_ok [2];
   logic [31:0]  img_len [2];
   logic [31:0]  img_crc [2];
   logic [31:0]  img_seq [2];
   logic [31:0]  crc_acc [2];
   logic [16:0]  bytes_seen [2];
   verdict_type  verdicts_due[$];
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;

   function automatic logic [31:0] crc_next(input logic [31:0] acc, input logic [7:0] d);
      logic [31:0] r;
      int          i;
      r = acc;
      for (i = 0; i < 8; i++) begin
         if (r[0] ^ d[i]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   function automatic logic bank_passes(input int b);
      return hdr_ok[b] && bytes_seen[b] != COUNT_SAT && {15'd0, bytes_seen[b]} == img_len[b]
             && ~crc_acc[b] == img_crc[b];
   endfunction

   function automatic void predict_transfer(input req_item_type it);
      logic [16:0] lim;
      logic        ga;
      logic        gb;
      verdict_type v;
      int          b;
      b = int'(it.bank);
      case (it.operation)
         OP_HEADER: begin
            lim = (size_limit > SIZE_CAP) ? 17'(SIZE_CAP) : size_limit;
            hdr_ok[b] = it.magic == want_magic && it.valid_flag == 32'd1 &&
                        it.size_bytes != 32'd0 && it.size_bytes <= {15'd0, lim} &&
                        it.schema_tag == want_schema;
            img_len[b] = it.size_bytes;
            img_crc[b] = it.crc_value;
            img_seq[b] = it.sequence_req;
            crc_acc[b] = CRC_SEED;
            bytes_seen[b] = '0;
         end
         OP_DATA: begin
            crc_acc[b] = crc_next(crc_acc[b], it.data_byte);
            if (bytes_seen[b] != COUNT_SAT) bytes_seen[b] = bytes_seen[b] + 17'd1;
         end
         OP_DECIDE: begin
            ga = bank_passes(0);
            gb = bank_passes(1);
            if (ga && (!gb || img_seq[1] <= img_seq[0])) begin
               v.active_bank = ACTIVE_A;
               v.active_sequence = img_seq[0];
            end else if (gb) begin
               v.active_bank = ACTIVE_B;
               v.active_sequence = img_seq[1];
            end else begin
               v.active_bank = ACTIVE_NONE;
               v.active_sequence = '0;
            end
            v.bank_a_good = ga;
            v.bank_b_good = gb;
            v.next_target_bank = (v.active_bank == ACTIVE_A);
            v.next_sequence = v.active_sequence + 32'd1;
            verdicts_due.push_back(v);
         end
         default: ;
      endcase
   endfunction

   // stimulus helpers
   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_item_type scrap_item(input logic [1:0] op);
      req_item_type it;
      it.operation = op;
      it.bank = 1'($urandom);
      it.magic = $urandom;
      it.valid_flag = $urandom;
      it.size_bytes = $urandom;
      it.crc_value = $urandom;
      it.sequence_req = $urandom;
      it.schema_tag = rand64();
      it.data_byte = 8'($urandom);
      return it;
   endfunction

   function automatic req_item_type header_item(input logic b, input logic [31:0] size,
                                                input logic [31:0] crc, input logic [31:0] seq);
      req_item_type it;
      it = scrap_item(OP_HEADER);
      it.bank = b;
      it.magic = stim_magic;
      it.valid_flag = 32'd1;
      it.size_bytes = size;
      it.crc_value = crc;
      it.sequence_req = seq;
      it.schema_tag = stim_schema;
      return it;
   endfunction

   function automatic req_item_type data_item(input logic b, input logic [7:0] d);
      req_item_type it;
      it = scrap_item(OP_DATA);
      it.bank = b;
      it.data_byte = d;
      return it;
   endfunction

   function automatic void queue_item(input req_item_type it);
      pending_items.push_back(it);
      if (it.operation != OP_UNUSED) image_items++;
   endfunction

   function automatic void queue_decide();
      queue_item(scrap_item(OP_DECIDE));
   endfunction

   function automatic void stage_image(input logic b, input logic [31:0] size,
                                       input int unsigned n, input flaw_type flaw);
      req_item_type h;
      logic [7:0]   body[$];
      logic [31:0]  acc;
      logic [7:0]   d;
      acc = CRC_SEED;
      repeat (n) begin
         d = 8'($urandom);
         body.push_back(d);
         acc = crc_next(acc, d);
      end
      h = header_item(b, size, ~acc, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3));
      case (flaw)
         FLAW_MAGIC:  h.magic = h.magic ^ (32'd1 << $urandom_range(0, 31));
         FLAW_VALID:  h.valid_flag = $urandom;
         FLAW_SCHEMA: h.schema_tag = h.schema_tag ^ (64'd1 << $urandom_range(0, 63));
         FLAW_CRC:    h.crc_value = h.crc_value ^ (32'd1 << $urandom_range(0, 31));
         default: ;
      endcase
      if (flaw != FLAW_HEADERLESS) staged[b].push_back(h);
      foreach (body[i]) staged[b].push_back(data_item(b, body[i]));
   endfunction

   function automatic void stage_random(input logic b);
      int unsigned eff;
      int unsigned size_max;
      int unsigned n;
      logic [31:0] size;
      flaw_type    flaw;
      eff = 32'(stim_limit);
      if (eff > SIZE_CAP) eff = SIZE_CAP;
      size_max = ($urandom_range(0, 19) == 0) ? 100 : 12;
      if (size_max > eff) size_max = eff;
      size = $urandom_range(1, size_max);
      n = size;
      flaw = ($urandom_range(0, 3) == 0) ? flaw_type'($urandom_range(1, 9)) : FLAW_NONE;
      case (flaw)
         FLAW_SIZE_ZERO: begin
            size = '0;
            n = $urandom_range(0, 3);
         end
         FLAW_OVERSIZE: begin
            size = $urandom_range(0, 1) ? eff + $urandom_range(1, 4) : $urandom;
            if (size <= eff) size = eff + 1;
            n = $urandom_range(0, 6);
         end
         FLAW_SHORT: n = size - 1;
         FLAW_LONG:  n = size + 1;
         default: ;
      endcase
      stage_image(b, size, n, flaw);
   endfunction

   // interleave the two banks' streams, each kept in order
   function automatic void merge_staged();
      int unsigned pick;
      while (staged[0].size() != 0 || staged[1].size() != 0) begin
         if (staged[0].size() == 0) pick = 1;
         else if (staged[1].size() == 0) pick = 0;
         else pick = $urandom_range(0, 1);
         queue_item(staged[pick].pop_front());
      end
   endfunction

   task automatic drain();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_bus.valid || verdicts_due.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [31:0] magic, input logic [16:0] limit,
                             input logic [63:0] schema);
      write_reg(CSR_EXPECTED_MAGIC, {32'd0, magic});
      write_reg(CSR_MAX_IMAGE_BYTES, {47'd0, limit});
      write_reg(CSR_EXPECTED_SCHEMA, schema);
      stim_magic = magic;
      stim_limit = limit;
      stim_schema = schema;
   endtask

   task automatic random_phase(input int unsigned quota);
      int unsigned stop_at;
      logic        b;
      stop_at = image_items + quota;
      while (image_items < stop_at) begin
         if ($urandom_range(0, 9) < 8) begin
            b = 1'($urandom);
            stage_random(b);
            if ($urandom_range(0, 2) == 0) stage_random(~b);
            merge_staged();
         end else begin
            repeat ($urandom_range(1, 4)) queue_item(scrap_item(2'($urandom_range(0, 3))));
         end
         if ($urandom_range(0, 3) != 0) queue_decide();
         if ($urandom_range(0, 7) == 0) queue_decide();
      end
      drain();
   endtask

   // request driver
   int unsigned send_gap = 0;

   always @(posedge clock) begin : drive_req
      req_item_type it;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap != 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 6);
            req_bus.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            it = pending_items.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.operation <= it.operation;
            req_bus.bank <= it.bank;
            req_bus.magic <= it.magic;
            req_bus.valid_flag <= it.valid_flag;
            req_bus.size_bytes <= it.size_bytes;
            req_bus.crc_value <= it.crc_value;
            req_bus.sequence_req <= it.sequence_req;
            req_bus.schema_tag <= it.schema_tag;
            req_bus.data_byte <= it.data_byte;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result receiver; one long hold-off once traffic is flowing
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   int unsigned results_taken = 0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin : drive_rsp
      if (rsp_bus.valid && rsp_bus.ready) results_taken++;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && results_taken >= 25) begin
         hold_done = 1'b1;
         hold_left = 399;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin : check
      verdict_type  got;
      verdict_type  exp;
      req_item_type it;
      int           k;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else if (reset) begin
         want_magic = '0;
         size_limit = MAX_BYTES_RESET;
         want_schema = '0;
         for (k = 0; k < 2; k++) begin
            hdr_ok[k] = 1'b0;
            img_len[k] = '0;
            img_crc[k] = '0;
            img_seq[k] = '0;
            crc_acc[k] = CRC_SEED;
            bytes_seen[k] = '0;
         end
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_EXPECTED_MAGIC:  want_magic = csr_write_data[31:0];
               CSR_MAX_IMAGE_BYTES: size_limit = csr_write_data[16:0];
               CSR_EXPECTED_SCHEMA: want_schema = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.active_bank, rsp_bus.active_sequence, rsp_bus.bank_a_good,
                   rsp_bus.bank_b_good, rsp_bus.next_target_bank, rsp_bus.next_sequence};
            if (verdicts_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result transfer bank %0d seq %h", $realtime,
                           got.active_bank, got.active_sequence);
            end else begin
               exp = verdicts_due.pop_front();
               if (got !== exp) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: decide mismatch: exp bank %0d seq %h good %b%b next %0d/%h,",
                               " got bank %0d seq %h good %b%b next %0d/%h"}, $realtime,
                              exp.active_bank, exp.active_sequence, exp.bank_a_good,
                              exp.bank_b_good, exp.next_target_bank, exp.next_sequence,
                              got.active_bank, got.active_sequence, got.bank_a_good,
                              got.bank_b_good, got.next_target_bank, got.next_sequence);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            it = {req_bus.operation, req_bus.bank, req_bus.magic, req_bus.valid_flag,
                  req_bus.size_bytes, req_bus.crc_value, req_bus.sequence_req,
                  req_bus.schema_tag, req_bus.data_byte};
            predict_transfer(it);
         end
      end
   end

   initial begin : run
      req_item_type h;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset config, empty banks, data with no header, unused opcode
      queue_decide();
      queue_item(data_item(1'b0, 8'hFF));
      queue_decide();
      queue_item(scrap_item(OP_UNUSED));
      // both good with top sequence: tie goes to A, next sequence wraps
      queue_item(header_item(1'b0, 32'd1, ~crc_next(CRC_SEED, 8'h00), 32'hFFFF_FFFF));
      queue_item(data_item(1'b0, 8'h00));
      queue_item(header_item(1'b1, 32'd2, ~crc_next(crc_next(CRC_SEED, 8'hFF), 8'h80),
                             32'hFFFF_FFFF));
      queue_item(data_item(1'b1, 8'hFF));
      queue_item(data_item(1'b1, 8'h80));
      queue_decide();
      h = header_item(1'b0, 32'd1, ~crc_next(CRC_SEED, 8'h00), 32'd0);
      h.valid_flag = '1;
      queue_item(h);
      queue_item(data_item(1'b0, 8'h00));
      queue_decide();
      queue_item(header_item(1'b0, 32'd0, 32'd0, 32'd5));
      queue_decide();
      queue_item(header_item(1'b0, 32'd65537, 32'd0, 32'd7));
      queue_decide();
      h = header_item(1'b1, 32'd2, ~crc_next(crc_next(CRC_SEED, 8'hFF), 8'h80), 32'd3);
      h.schema_tag = ~stim_schema;
      queue_item(h);
      queue_decide();
      drain();

      // all-ones match values, size limit of one byte
      set_config('1, 17'd1, '1);
      queue_item(header_item(1'b0, 32'd1, ~crc_next(CRC_SEED, 8'hA5), 32'd0));
      queue_item(data_item(1'b0, 8'hA5));
      queue_item(header_item(1'b1, 32'd2, ~crc_next(crc_next(CRC_SEED, 8'h01), 8'h02), 32'd9));
      queue_item(data_item(1'b1, 8'h01));
      queue_item(data_item(1'b1, 8'h02));
      queue_decide();
      drain();

      set_config($urandom, 17'($urandom_range(4, 64)), rand64());
      random_phase(160);
      set_config(32'd0, 17'h10000, 64'd0);
      random_phase(160);
      set_config('1, 17'($urandom_range(1, 16)), '1);
      random_phase(160);
      set_config($urandom, 17'($urandom_range(1, 65536)), rand64());
      random_phase(160);

      // no idling from here
      quiet = 1'b1;
      set_config($urandom, 17'h10000, rand64());
      random_phase(80);

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && verdicts_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
+incdir+sv
sv/dbis_pkg.sv
sv/dbis_req_if.sv
sv/dbis_rsp_if.sv
sv/dbis_bank.sv
sv/dual_bank_image_selector.sv
tb/sv/testbench.sv
